// File: rtl/core/bbc_pkg.sv
// Shared types and constants of the block buffer cache tag store.
package bbc_pkg;

   localparam int ENTRIES_DEF     = 32;
   localparam int DEVICE_BITS_DEF = 8;

   localparam int DEV_W    = 8;
   localparam int BLK_W    = 32;
   localparam int ENTRY_W  = 5;
   localparam int STATUS_W = 3;

   localparam logic FUNC_GET     = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REL_ERR   = 3'd4;

   // Operation on the free list for one cycle.
   typedef struct packed {
      logic push;
      logic remove;
      logic pop_tail;
   } fl_op_type;

endpackage

// File: rtl/core/bbc_if.sv
// Request and response channel interfaces of the block buffer cache.
interface bbc_req_if;
   import bbc_pkg::*;
   logic               valid;
   logic               ready;
   logic               func;
   logic [DEV_W-1:0]   device;
   logic [BLK_W-1:0]   block_number;
   logic [ENTRY_W-1:0] entry_index;
   logic               contents_valid;
   logic               contents_dirty;
   modport source (output valid, func, device, block_number, entry_index,
                   contents_valid, contents_dirty, input ready);
   modport sink   (input valid, func, device, block_number, entry_index,
                   contents_valid, contents_dirty, output ready);
endinterface

interface bbc_rsp_if;
   import bbc_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRY_W-1:0]  entry;
   logic                needs_read;
   logic                writeback;
   logic [DEV_W-1:0]    victim_device;
   logic [BLK_W-1:0]    victim_block;
   modport source (output valid, status, entry, needs_read, writeback,
                   victim_device, victim_block, input ready);
   modport sink   (input valid, status, entry, needs_read, writeback,
                   victim_device, victim_block, output ready);
endinterface

// File: rtl/core/block_buffer_cache_lru.sv
// Top level of the block buffer cache tag store with least-recently-released replacement.
// A get beat looks its (device, block number) key up by walking the tag memory one entry
// a cycle through a single shared comparator. A hit on a free entry then walks the free
// list one position a cycle to find and unlink it; a miss takes the entry at the victim
// end of the free list, reads its old tag, reports a write-back if it was dirty and
// rekeys it with its valid and dirty marks cleared. A release beat checks that the entry
// is held, records the marks and puts the entry at the most recent end. Every request
// beat gives exactly one response beat. The request side is ready only between requests,
// but a finished response waits in its own register, so the next request is taken while
// the previous response is still unclaimed. No clearing pass follows reset: tags are only
// trusted once their assigned bit is set.
module block_buffer_cache_lru #(
   parameter int ENTRIES     = bbc_pkg::ENTRIES_DEF,
   parameter int DEVICE_BITS = bbc_pkg::DEVICE_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   bbc_req_if.sink  req_chan,
   bbc_rsp_if.source rsp_chan
);
   import bbc_pkg::*;

   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES+1);
   localparam int TAG_DEV_W = (DEVICE_BITS < DEV_W) ? DEVICE_BITS : DEV_W;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_HIT, S_FIND, S_MISS, S_VRD, S_FILL, S_REL, S_DONE
   } state_type;

   state_type state_ff;

   // Captured request.
   logic [TAG_DEV_W-1:0] key_dev_ff;
   logic [BLK_W-1:0]     key_blk_ff;
   logic [ENTRY_W-1:0]   rel_raw_ff;
   logic                 cval_ff, cdirty_ff;

   // Per-entry marks, cleared by reset.
   logic [ENTRIES-1:0] assigned_ff, held_ff, valid_ff, dirty_ff;

   // Walk counters.
   logic [IDX_W-1:0] scan_ff, cmp_idx_ff, pos_ff, hit_ff, victim_ff;
   logic             cmp_vld_ff;

   // Result waiting to be handed to the response register.
   logic [STATUS_W-1:0] res_status_ff;
   logic [IDX_W-1:0]    res_entry_ff;
   logic                res_read_ff, res_wb_ff;
   logic [DEV_W-1:0]    res_vdev_ff;
   logic [BLK_W-1:0]    res_vblk_ff;
   logic                res_zero_entry_ff;

   // Response register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ENTRY_W-1:0]  rsp_entry_ff;
   logic                rsp_read_ff, rsp_wb_ff;
   logic [DEV_W-1:0]    rsp_vdev_ff;
   logic [BLK_W-1:0]    rsp_vblk_ff;

   // Marks whether the current request is a release.
   logic                rel_fired_ff;

   // Tag memory and free list connections.
   logic                 tag_we;
   logic [IDX_W-1:0]     tag_raddr;
   logic [TAG_DEV_W-1:0] rdev;
   logic [BLK_W-1:0]     rblk;
   fl_op_type            fl_op;
   logic [IDX_W-1:0]     fl_pos, fl_entry;
   logic [CNT_W-1:0]     fl_count;

   logic       req_fire, rsp_load;
   logic       tag_match;
   logic [IDX_W-1:0] rel_idx;
   logic       rel_ok;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rel_idx   = IDX_W'(rel_raw_ff);
   assign rel_ok    = (32'(rel_raw_ff) < ENTRIES) && held_ff[rel_idx];

   // The one comparator that every step of the tag walk goes through.
   assign tag_match = assigned_ff[cmp_idx_ff] && (rdev == key_dev_ff) && (rblk == key_blk_ff);

   assign tag_we    = (state_ff == S_FILL);
   assign tag_raddr = (state_ff == S_SCAN) ? scan_ff : victim_ff;
   assign fl_pos    = (state_ff == S_MISS) ? IDX_W'(fl_count - CNT_W'(1)) : pos_ff;

   always_comb begin
      fl_op          = '0;
      fl_op.push     = (state_ff == S_REL) && rel_ok;
      fl_op.remove   = (state_ff == S_FIND) && (fl_entry == hit_ff);
      fl_op.pop_tail = (state_ff == S_MISS) && (fl_count != CNT_W'(0));
   end

   bbc_tag_ram #(.ENTRIES(ENTRIES), .TAG_DEV_W(TAG_DEV_W)) u_tag_ram (
      .clock   (clock),
      .we      (tag_we),
      .waddr   (victim_ff),
      .wdev    (key_dev_ff),
      .wblk    (key_blk_ff),
      .raddr   (tag_raddr),
      .rdev_ff (rdev),
      .rblk_ff (rblk)
   );

   bbc_free_list #(.ENTRIES(ENTRIES)) u_free_list (
      .clock      (clock),
      .reset      (reset),
      .op         (fl_op),
      .push_entry (rel_idx),
      .pos        (fl_pos),
      .rd_entry   (fl_entry),
      .count      (fl_count)
   );

   // Sequencer: state, marks and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         assigned_ff  <= '0;
         held_ff      <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  key_dev_ff  <= req_chan.device[TAG_DEV_W-1:0];
                  key_blk_ff  <= req_chan.block_number;
                  rel_raw_ff  <= req_chan.entry_index;
                  cval_ff     <= req_chan.contents_valid;
                  cdirty_ff   <= req_chan.contents_dirty;
                  scan_ff     <= '0;
                  cmp_vld_ff  <= 1'b0;
                  res_read_ff <= 1'b0;
                  res_wb_ff   <= 1'b0;
                  res_vdev_ff <= '0;
                  res_vblk_ff <= '0;
                  res_zero_entry_ff <= 1'b0;
                  state_ff    <= (req_chan.func == FUNC_RELEASE) ? S_REL : S_SCAN;
               end
            end
            S_SCAN: begin
               // Read address scan_ff now, compare the entry read last cycle.
               cmp_vld_ff <= 1'b1;
               cmp_idx_ff <= scan_ff;
               if (scan_ff != IDX_W'(ENTRIES-1)) begin
                  scan_ff <= scan_ff + IDX_W'(1);
               end
               if (cmp_vld_ff) begin
                  if (tag_match) begin
                     hit_ff   <= cmp_idx_ff;
                     state_ff <= S_HIT;
                  end else if (cmp_idx_ff == IDX_W'(ENTRIES-1)) begin
                     state_ff <= S_MISS;
                  end
               end
            end
            S_HIT: begin
               res_entry_ff <= hit_ff;
               if (held_ff[hit_ff]) begin
                  res_status_ff <= ST_BUSY;
                  state_ff      <= S_DONE;
               end else begin
                  pos_ff   <= '0;
                  state_ff <= S_FIND;
               end
            end
            S_FIND: begin
               if (fl_entry == hit_ff) begin
                  held_ff[hit_ff] <= 1'b1;
                  res_status_ff   <= ST_HIT;
                  res_read_ff     <= !valid_ff[hit_ff];
                  state_ff        <= S_DONE;
               end else begin
                  pos_ff <= pos_ff + IDX_W'(1);
               end
            end
            S_MISS: begin
               if (fl_count == CNT_W'(0)) begin
                  res_status_ff     <= ST_NONE_FREE;
                  res_zero_entry_ff <= 1'b1;
                  state_ff          <= S_DONE;
               end else begin
                  victim_ff <= fl_entry;
                  state_ff  <= S_VRD;
               end
            end
            S_VRD: begin
               state_ff <= S_FILL;
            end
            S_FILL: begin
               // Old tag of the victim is on the read port now; it is overwritten this edge.
               if (assigned_ff[victim_ff] && dirty_ff[victim_ff]) begin
                  res_wb_ff   <= 1'b1;
                  res_vdev_ff <= DEV_W'(rdev);
                  res_vblk_ff <= rblk;
               end
               assigned_ff[victim_ff] <= 1'b1;
               held_ff[victim_ff]     <= 1'b1;
               valid_ff[victim_ff]    <= 1'b0;
               dirty_ff[victim_ff]    <= 1'b0;
               res_status_ff          <= ST_ALLOC;
               res_entry_ff           <= victim_ff;
               res_read_ff            <= 1'b1;
               state_ff               <= S_DONE;
            end
            S_REL: begin
               if (rel_ok) begin
                  held_ff[rel_idx]  <= 1'b0;
                  valid_ff[rel_idx] <= cval_ff;
                  dirty_ff[rel_idx] <= cdirty_ff;
                  res_status_ff     <= ST_HIT;
               end else begin
                  res_status_ff     <= ST_REL_ERR;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Response payload; a release reports the raw index it was given.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         if (res_zero_entry_ff) begin
            rsp_entry_ff <= '0;
         end else if ((res_status_ff == ST_REL_ERR) ||
                      ((res_status_ff == ST_HIT) && !res_read_ff && rel_fired_ff)) begin
            rsp_entry_ff <= rel_raw_ff;
         end else begin
            rsp_entry_ff <= ENTRY_W'(res_entry_ff);
         end
         rsp_read_ff <= res_read_ff;
         rsp_wb_ff   <= res_wb_ff;
         rsp_vdev_ff <= res_vdev_ff;
         rsp_vblk_ff <= res_vblk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_fired_ff <= 1'b0;
      end else if (req_fire) begin
         rel_fired_ff <= (req_chan.func == FUNC_RELEASE);
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.entry         = rsp_entry_ff;
   assign rsp_chan.needs_read    = rsp_read_ff;
   assign rsp_chan.writeback     = rsp_wb_ff;
   assign rsp_chan.victim_device = rsp_vdev_ff;
   assign rsp_chan.victim_block  = rsp_vblk_ff;

   // Every entry is either held or on the free list, except that a victim has already
   // left the free list while its rekey is still in progress.
   a_count_balance: assert property (@(posedge clock) disable iff (reset)
      ($countones(held_ff) + int'(fl_count) +
       (((state_ff == S_VRD) || (state_ff == S_FILL)) ? 1 : 0)) == ENTRIES)
      else $error("held entries and free list count disagree");

   // A rekeyed victim is held from the next cycle on.
   a_victim_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |=> held_ff[$past(victim_ff)])
      else $error("victim not held after rekey");

   // A victim is only claimed from a non-empty free list.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      fl_op.pop_tail |-> (fl_count != CNT_W'(0)))
      else $error("pop from empty free list");
endmodule

// File: rtl/core/bbc_tag_ram.sv
// Tag memory: device and block number of each entry, one write and one read port.
module bbc_tag_ram #(
   parameter int ENTRIES = 32,
   parameter int TAG_DEV_W = 8
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(ENTRIES)-1:0] waddr,
   input  logic [TAG_DEV_W-1:0]       wdev,
   input  logic [bbc_pkg::BLK_W-1:0]  wblk,
   input  logic [$clog2(ENTRIES)-1:0] raddr,
   output logic [TAG_DEV_W-1:0]       rdev_ff,
   output logic [bbc_pkg::BLK_W-1:0]  rblk_ff
);
   import bbc_pkg::*;

   logic [TAG_DEV_W+BLK_W-1:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= {wdev, wblk};
      end
      {rdev_ff, rblk_ff} <= mem[raddr];
   end
endmodule

// File: rtl/core/bbc_free_list.sv
// Free list in recency order: position 0 is the most recent end.
module bbc_free_list #(
   parameter int ENTRIES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bbc_pkg::fl_op_type             op,
   input  logic [$clog2(ENTRIES)-1:0]     push_entry,
   input  logic [$clog2(ENTRIES)-1:0]     pos,
   output logic [$clog2(ENTRIES)-1:0]     rd_entry,
   output logic [$clog2(ENTRIES+1)-1:0]   count
);
   import bbc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES+1);

   logic [IDX_W-1:0] order_ff [ENTRIES];
   logic [IDX_W-1:0] order_in [ENTRIES];
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      order_in = order_ff;
      count_in = count_ff;
      if (op.push) begin
         for (int k = 1; k < ENTRIES; k++) begin
            order_in[k] = order_ff[k-1];
         end
         order_in[0] = push_entry;
         count_in    = count_ff + CNT_W'(1);
      end else if (op.remove) begin
         for (int k = 0; k < ENTRIES-1; k++) begin
            if (IDX_W'(k) >= pos) begin
               order_in[k] = order_ff[k+1];
            end
         end
         count_in = count_ff - CNT_W'(1);
      end else if (op.pop_tail) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ENTRIES; k++) begin
            order_ff[k] <= IDX_W'(ENTRIES - 1 - k);
         end
         count_ff <= CNT_W'(ENTRIES);
      end else begin
         order_ff <= order_in;
         count_ff <= count_in;
      end
   end

   assign rd_entry = order_ff[pos];
   assign count    = count_ff;
endmodule

// File: tb/block_buffer_cache_lru_tb.sv
// Self-checking testbench for the block buffer cache tag store with LRU replacement.
`timescale 1ns / 100ps

module block_buffer_cache_lru_tb;
   import bbc_pkg::*;

   localparam int N_ENTRIES   = ENTRIES_DEF;
   localparam int N_RANDOM    = 1430;
   localparam int CYCLE_LIMIT = 2000000;
   // The long hold-off on the response side starts after this many response beats.
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 600;

   // One request beat as the sender presents it.
   typedef struct {
      logic               func;
      logic [DEV_W-1:0]   device;
      logic [BLK_W-1:0]   block_number;
      logic [ENTRY_W-1:0] entry_index;
      logic               contents_valid;
      logic               contents_dirty;
   } cache_req_type;

   // One response beat as the block should give it.
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  entry;
      logic                needs_read;
      logic                writeback;
      logic [DEV_W-1:0]    victim_device;
      logic [BLK_W-1:0]    victim_block;
   } cache_rsp_type;

   logic clock;
   logic reset;
   bit   failed;
   int   cycle_count;

   bbc_req_if req_chan ();
   bbc_rsp_if rsp_chan ();

   block_buffer_cache_lru dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Shadow copy of the tag store. The free list holds entry numbers with the most
   // recently released entry at the front and the next victim at the back.
   logic [DEV_W-1:0] tag_dev_sh [N_ENTRIES];
   logic [BLK_W-1:0] tag_blk_sh [N_ENTRIES];
   bit               assigned_sh [N_ENTRIES];
   bit               held_sh [N_ENTRIES];
   bit               valid_sh [N_ENTRIES];
   bit               dirty_sh [N_ENTRIES];
   int               lru_list [$];

   // Request beats still to be offered, and the response each one must cause.
   cache_req_type pending_reqs [$];
   cache_rsp_type pending_rsps [$];
   // Responses owed by the block for requests it has already taken, oldest first.
   cache_rsp_type rsp_due [$];

   // Works out the response to one request and advances the shadow state. Requests
   // are accepted in the order they are queued, so running this as they are queued
   // gives the same answers as running it at acceptance.
   function automatic cache_rsp_type cache_predict(cache_req_type rq);
      cache_rsp_type r;
      int         hit;
      int         victim;
      r = '{default: '0};
      if (rq.func == FUNC_RELEASE) begin
         r.entry = rq.entry_index;
         if (rq.entry_index >= N_ENTRIES || !held_sh[rq.entry_index] ||
             lru_list.size() >= N_ENTRIES) begin
            r.status = ST_REL_ERR;
            return r;
         end
         held_sh[rq.entry_index]  = 1'b0;
         valid_sh[rq.entry_index] = rq.contents_valid;
         dirty_sh[rq.entry_index] = rq.contents_dirty;
         lru_list.push_front(rq.entry_index);
         r.status = ST_HIT;
         return r;
      end
      hit = -1;
      for (int i = 0; i < N_ENTRIES; i++) begin
         if (hit < 0 && assigned_sh[i] && tag_dev_sh[i] == rq.device &&
             tag_blk_sh[i] == rq.block_number) begin
            hit = i;
         end
      end
      if (hit >= 0) begin
         r.entry = ENTRY_W'(hit);
         if (held_sh[hit]) begin
            r.status = ST_BUSY;
            return r;
         end
         for (int p = 0; p < lru_list.size(); p++) begin
            if (lru_list[p] == hit) begin
               lru_list.delete(p);
               break;
            end
         end
         held_sh[hit] = 1'b1;
         r.status     = ST_HIT;
         r.needs_read = !valid_sh[hit];
         return r;
      end
      if (lru_list.size() == 0) begin
         r.status = ST_NONE_FREE;
         return r;
      end
      victim = lru_list.pop_back();
      if (assigned_sh[victim] && dirty_sh[victim]) begin
         r.writeback     = 1'b1;
         r.victim_device = tag_dev_sh[victim];
         r.victim_block  = tag_blk_sh[victim];
      end
      tag_dev_sh[victim]  = rq.device;
      tag_blk_sh[victim]  = rq.block_number;
      assigned_sh[victim] = 1'b1;
      valid_sh[victim]    = 1'b0;
      dirty_sh[victim]    = 1'b0;
      held_sh[victim]     = 1'b1;
      r.status     = ST_ALLOC;
      r.entry      = ENTRY_W'(victim);
      r.needs_read = 1'b1;
      return r;
   endfunction

   task automatic queue_req(input logic func, input logic [DEV_W-1:0] dev,
                            input logic [BLK_W-1:0] blk, input logic [ENTRY_W-1:0] idx,
                            input logic cv, input logic cd);
      cache_req_type rq;
      rq = '{func, dev, blk, idx, cv, cd};
      pending_reqs.push_back(rq);
      pending_rsps.push_back(cache_predict(rq));
   endtask

   // A key from a small pool, so that gets often hit and the pool outgrows the
   // cache; now and then a fully random key so every bit of both fields moves.
   task automatic queue_get();
      logic [DEV_W-1:0] dev;
      logic [BLK_W-1:0] blk;
      if ($urandom_range(0, 9) < 7) begin
         dev = ($urandom_range(0, 4) == 0) ? 8'hFF : DEV_W'($urandom_range(0, 2));
         blk = BLK_W'($urandom_range(0, 15));
         if ($urandom_range(0, 5) == 0) blk = ~blk;
      end else begin
         dev = DEV_W'($urandom);
         blk = $urandom;
      end
      queue_req(FUNC_GET, dev, blk, ENTRY_W'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Mostly a release of an entry that really is held, otherwise any index.
   task automatic queue_release();
      int held_list [$];
      logic [ENTRY_W-1:0] idx;
      for (int i = 0; i < N_ENTRIES; i++) begin
         if (held_sh[i]) held_list.push_back(i);
      end
      if (held_list.size() > 0 && $urandom_range(0, 99) < 85) begin
         idx = ENTRY_W'(held_list[$urandom_range(0, held_list.size() - 1)]);
      end else begin
         idx = ENTRY_W'($urandom);
      end
      queue_req(FUNC_RELEASE, DEV_W'($urandom), $urandom, idx, 1'($urandom),
                1'($urandom));
   endtask

   // Stimulus and end of run.
   initial begin
      int release_pct;
      req_chan.valid          = 1'b0;
      req_chan.func           = FUNC_GET;
      req_chan.device         = '0;
      req_chan.block_number   = '0;
      req_chan.entry_index    = '0;
      req_chan.contents_valid = 1'b0;
      req_chan.contents_dirty = 1'b0;
      rsp_chan.ready          = 1'b0;
      reset = 1'b1;

      for (int i = 0; i < N_ENTRIES; i++) begin
         assigned_sh[i] = 1'b0;
         held_sh[i]     = 1'b0;
         valid_sh[i]    = 1'b0;
         dirty_sh[i]    = 1'b0;
         tag_dev_sh[i]  = '0;
         tag_blk_sh[i]  = '0;
         lru_list.push_back(N_ENTRIES - 1 - i);
      end

      // Directed part: extreme keys, a busy hit, releases with every mark
      // combination, a hit with and without valid contents, and release errors on
      // entries that are not held.
      queue_req(FUNC_GET, 8'h00, 32'h0000_0000, '0, 1'b0, 1'b0);
      queue_req(FUNC_GET, 8'hFF, 32'hFFFF_FFFF, '0, 1'b0, 1'b0);
      queue_req(FUNC_GET, 8'h00, 32'h0000_0000, '0, 1'b0, 1'b0);
      queue_req(FUNC_RELEASE, '0, '0, 5'd0, 1'b1, 1'b1);
      queue_req(FUNC_RELEASE, '0, '0, 5'd0, 1'b0, 1'b0);
      queue_req(FUNC_RELEASE, '0, '0, 5'd31, 1'b1, 1'b0);
      queue_req(FUNC_GET, 8'h00, 32'h0000_0000, '0, 1'b0, 1'b0);
      queue_req(FUNC_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b1);
      queue_req(FUNC_RELEASE, '0, '0, 5'd1, 1'b0, 1'b1);
      queue_req(FUNC_GET, 8'hFF, 32'hFFFF_FFFF, '0, 1'b0, 1'b0);
      queue_req(FUNC_RELEASE, '0, '0, 5'd1, 1'b0, 1'b0);
      queue_req(FUNC_GET, 8'h12, 32'h8000_0001, '0, 1'b0, 1'b0);
      queue_req(FUNC_GET, 8'h34, 32'h7FFF_FFFE, '0, 1'b0, 1'b0);

      // Random part in phases: release-heavy phases keep the free list full and
      // force evictions; get-heavy phases drain it until gets find nothing free.
      for (int n = 0; n < N_RANDOM; n++) begin
         case ((n / 120) % 3)
            0: begin
               release_pct = 50;
            end
            1: begin
               release_pct = 15;
            end
            default: begin
               release_pct = 35;
            end
         endcase
         if ($urandom_range(0, 99) < release_pct) queue_release();
         else queue_get();
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && rsp_due.size() == 0);
      repeat (100) @(posedge clock);
      if (!failed && rsp_due.size() == 0) begin
         $display("block_buffer_cache_lru_tb: clean");
      end else begin
         $display("block_buffer_cache_lru_tb: errors");
      end
      $finish;
   end

   // Driver. Acceptance is seen at the rising edge; the next beat or a gap is set
   // up at the falling edge. Beats 601 to 800 are sent back to back.
   int  send_gap;
   bit  req_taken;
   int  sent_count;

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         rsp_due.push_back(pending_rsps.pop_front());
         void'(pending_reqs.pop_front());
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (!reset && (req_taken || !req_chan.valid)) begin
         if (send_gap > 0 || pending_reqs.size() == 0) begin
            req_chan.valid = 1'b0;
            if (send_gap > 0) send_gap--;
         end else begin
            req_chan.valid          = 1'b1;
            req_chan.func           = pending_reqs[0].func;
            req_chan.device         = pending_reqs[0].device;
            req_chan.block_number   = pending_reqs[0].block_number;
            req_chan.entry_index    = pending_reqs[0].entry_index;
            req_chan.contents_valid = pending_reqs[0].contents_valid;
            req_chan.contents_dirty = pending_reqs[0].contents_dirty;
            sent_count++;
            send_gap = (sent_count > 600 && sent_count < 800) ? 0 : $urandom_range(0, 6);
         end
      end
   end

   // Monitor. Each response beat is checked against the oldest owed response.
   int rsp_count;
   int ready_gap;
   int hold_left;

   always @(posedge clock) begin
      cache_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count <= rsp_count + 1;
         if (rsp_due.size() == 0) begin
            $error("response beat with none owed: status %0d entry %0d",
                   rsp_chan.status, rsp_chan.entry);
            failed <= 1'b1;
         end else begin
            want = rsp_due.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               failed <= 1'b1;
            end
            if (rsp_chan.entry !== want.entry) begin
               $error("entry: expected %0d, got %0d", want.entry, rsp_chan.entry);
               failed <= 1'b1;
            end
            if (rsp_chan.needs_read !== want.needs_read) begin
               $error("needs_read: expected %0d, got %0d", want.needs_read,
                      rsp_chan.needs_read);
               failed <= 1'b1;
            end
            if (rsp_chan.writeback !== want.writeback) begin
               $error("writeback: expected %0d, got %0d", want.writeback,
                      rsp_chan.writeback);
               failed <= 1'b1;
            end
            if (rsp_chan.victim_device !== want.victim_device) begin
               $error("victim_device: expected %0h, got %0h", want.victim_device,
                      rsp_chan.victim_device);
               failed <= 1'b1;
            end
            if (rsp_chan.victim_block !== want.victim_block) begin
               $error("victim_block: expected %0h, got %0h", want.victim_block,
                      rsp_chan.victim_block);
               failed <= 1'b1;
            end
         end
      end
   end

   // Ready is withdrawn for a random number of cycles after each beat, except for
   // an unbroken stretch in the middle, and once for a long hold-off so that the
   // response register fills and the block stops taking requests.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_count == HOLD_AT && hold_left == 0 && ready_gap >= 0) begin
            hold_left = HOLD_CYCLES;
            ready_gap = -1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            if (rsp_count > 900 && rsp_count < 1100) begin
               rsp_chan.ready = 1'b1;
            end else begin
               ready_gap = $urandom_range(0, 6);
               rsp_chan.ready = (ready_gap == 0);
            end
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_chan.ready = (ready_gap == 0);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("block_buffer_cache_lru_tb: errors");
         $finish;
      end
   end

endmodule
